[hw/rtl/gwmf_pkg.sv]
// ----------------------------------------------------------------------------
// gwmf_pkg
// shared types and constants of the gray window mode filter
// ----------------------------------------------------------------------------
package gwmf_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_RADIUS = 10;

   localparam int COORD_W    = 6;
   localparam int DIM_W      = 7;
   localparam int RAD_W      = 4;
   localparam int PIX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int BINS       = 256;
   localparam int BIN_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int WIDE_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SETUP,
      ST_ACCUM,
      ST_DRAIN,
      ST_SCAN,
      ST_FLUSH,
      ST_DONE
   } gwmf_state_type;

   typedef struct packed {
      logic load_we;
      logic capture;
      logic setup;
      logic issue;
      logic clear_bin;
      logic scan;
      logic out_load;
   } gwmf_cmd_type;

   typedef struct packed {
      logic win_empty;
      logic acc_last;
      logic pipe_busy;
      logic bin_last;
      logic out_free;
   } gwmf_status_type;

endpackage

[hw/rtl/gwmf_ctrl.sv]
// ----------------------------------------------------------------------------
// gwmf_ctrl
// sequencer: histogram clearing pass, window accumulation, bin scan, result
// ----------------------------------------------------------------------------
module gwmf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_ready,
   input  gwmf_pkg::gwmf_status_type status,
   output gwmf_pkg::gwmf_cmd_type    cmd
);
   import gwmf_pkg::*;

   gwmf_state_type state_ff, state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.clear_bin = 1'b1;
            if (status.bin_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept && (req_action == ACT_LOAD)) begin
               cmd.load_we = 1'b1;
            end
            if (accept && (req_action == ACT_COMPUTE)) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (status.win_empty) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (status.acc_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.bin_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

[hw/rtl/gwmf_datapath.sv]
// ----------------------------------------------------------------------------
// gwmf_datapath
// frame store, histogram memory, window walk, mode search and output register
// ----------------------------------------------------------------------------
module gwmf_datapath #(
   parameter int MAX_WIDTH  = gwmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gwmf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = gwmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gwmf_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [gwmf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [gwmf_pkg::COORD_W-1:0]      req_row,
   input  logic [gwmf_pkg::COORD_W-1:0]      req_col,
   input  logic [gwmf_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gwmf_pkg::PIX_W-1:0]        rsp_mode_value,
   output logic [gwmf_pkg::CNT_W-1:0]        rsp_mode_count,
   input  gwmf_pkg::gwmf_cmd_type            cmd,
   output gwmf_pkg::gwmf_status_type         status
);
   import gwmf_pkg::*;

   localparam int CB     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RB     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = CB + RB;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam logic [DIM_W-1:0] WIDTH_RST  =
      (MAX_WIDTH < 64) ? DIM_W'(MAX_WIDTH) : DIM_W'(64);
   localparam logic [DIM_W-1:0] HEIGHT_RST =
      (MAX_HEIGHT < 64) ? DIM_W'(MAX_HEIGHT) : DIM_W'(64);

   // configuration
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [DIM_W-1:0] wr_dim;
   logic [RAD_W-1:0] wr_rad;
   logic [DIM_W-1:0] width_clamp, height_clamp;
   logic [RAD_W-1:0] radius_clamp;

   assign wr_dim = csr_wdata;
   assign wr_rad = csr_wdata[RAD_W-1:0];

   always_comb begin
      if (wr_dim == '0) begin
         width_clamp  = DIM_W'(1);
         height_clamp = DIM_W'(1);
      end else begin
         width_clamp  = (int'(wr_dim) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : wr_dim;
         height_clamp = (int'(wr_dim) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : wr_dim;
      end
      if (wr_rad == '0) begin
         radius_clamp = RAD_W'(1);
      end else begin
         radius_clamp = (int'(wr_rad) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : wr_rad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         radius_ff <= RAD_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:   width_ff  <= width_clamp;
            CSR_IMAGE_HEIGHT:  height_ff <= height_clamp;
            CSR_WINDOW_RADIUS: radius_ff <= radius_clamp;
            default: begin
            end
         endcase
      end
   end

   // request capture and window bounds
   logic [COORD_W-1:0] row_ff, col_ff;
   logic [DIM_W-1:0]   r0_ff, r1_ff, c0_ff, c1_ff, y_ff, x_ff;
   logic [DIM_W-1:0]   rad7, row7, col7, row_sum, col_sum, hm1, wm1;
   logic [DIM_W-1:0]   r0_in, r1_in, c0_in, c1_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   assign rad7    = DIM_W'(radius_ff);
   assign row7    = DIM_W'(row_ff);
   assign col7    = DIM_W'(col_ff);
   assign row_sum = row7 + rad7;
   assign col_sum = col7 + rad7;
   assign hm1     = height_ff - DIM_W'(1);
   assign wm1     = width_ff - DIM_W'(1);
   assign r0_in   = (row7 >= rad7) ? row7 - rad7 : '0;
   assign c0_in   = (col7 >= rad7) ? col7 - rad7 : '0;
   assign r1_in   = (row_sum > hm1) ? hm1 : row_sum;
   assign c1_in   = (col_sum > wm1) ? wm1 : col_sum;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         c0_ff <= c0_in;
         c1_ff <= c1_in;
         y_ff  <= r0_in;
         x_ff  <= c0_in;
      end else if (cmd.issue) begin
         if (x_ff == c1_ff) begin
            x_ff <= c0_ff;
            y_ff <= y_ff + DIM_W'(1);
         end else begin
            x_ff <= x_ff + DIM_W'(1);
         end
      end
   end

   // frame store
   logic [PIX_W-1:0]  frame_mem [DEPTH];
   logic [PIX_W-1:0]  fr_data_ff;
   logic              fr_vld_ff;
   logic [WIDE_W-1:0] ld_row_w, ld_col_w, rd_row_w, rd_col_w;
   logic [ADDR_W-1:0] fr_wa, fr_ra;
   logic              ld_in_range;

   assign ld_row_w    = WIDE_W'(req_row);
   assign ld_col_w    = WIDE_W'(req_col);
   assign rd_row_w    = WIDE_W'(y_ff);
   assign rd_col_w    = WIDE_W'(x_ff);
   assign fr_wa       = {ld_row_w[RB-1:0], ld_col_w[CB-1:0]};
   assign fr_ra       = {rd_row_w[RB-1:0], rd_col_w[CB-1:0]};
   assign ld_in_range = (int'(req_row) < MAX_HEIGHT) && (int'(req_col) < MAX_WIDTH);

   always_ff @(posedge clock) begin
      if (cmd.load_we && ld_in_range) begin
         frame_mem[fr_wa] <= req_pixel_in;
      end
      fr_data_ff <= frame_mem[fr_ra];
   end

   // histogram memory with one-deep write forwarding
   logic [CNT_W-1:0] hist_mem [BINS];
   logic [CNT_W-1:0] hist_rd_ff;
   logic [BIN_W-1:0] hist_ra, hist_wa;
   logic [CNT_W-1:0] hist_wd, hist_base, hist_inc;
   logic             hist_we;
   logic             hs_vld_ff, lw_vld_ff, sc_vld_ff;
   logic [BIN_W-1:0] hs_addr_ff, lw_addr_ff, sc_idx_ff, bin_ff;
   logic [CNT_W-1:0] lw_data_ff;

   assign hist_base = (lw_vld_ff && (lw_addr_ff == hs_addr_ff)) ? lw_data_ff : hist_rd_ff;
   assign hist_inc  = hist_base + CNT_W'(1);
   assign hist_ra   = cmd.scan ? bin_ff : fr_data_ff;
   assign hist_we   = hs_vld_ff || cmd.scan || cmd.clear_bin;
   assign hist_wa   = hs_vld_ff ? hs_addr_ff : bin_ff;
   assign hist_wd   = hs_vld_ff ? hist_inc : '0;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
         hs_vld_ff <= 1'b0;
         lw_vld_ff <= 1'b0;
         sc_vld_ff <= 1'b0;
         bin_ff    <= '0;
      end else begin
         fr_vld_ff <= cmd.issue;
         hs_vld_ff <= fr_vld_ff;
         lw_vld_ff <= hs_vld_ff;
         sc_vld_ff <= cmd.scan;
         if (cmd.scan || cmd.clear_bin) begin
            bin_ff <= bin_ff + BIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      hs_addr_ff <= fr_data_ff;
      lw_addr_ff <= hs_addr_ff;
      lw_data_ff <= hist_inc;
      sc_idx_ff  <= bin_ff;
   end

   // mode search, lowest bin wins ties
   logic [PIX_W-1:0] best_val_ff;
   logic [CNT_W-1:0] best_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         best_val_ff <= '0;
         best_cnt_ff <= '0;
      end else if (sc_vld_ff && (hist_rd_ff > best_cnt_ff)) begin
         best_val_ff <= sc_idx_ff;
         best_cnt_ff <= hist_rd_ff;
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] mode_value_ff;
   logic [CNT_W-1:0] mode_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mode_value_ff <= best_val_ff;
         mode_count_ff <= best_cnt_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = mode_value_ff;
   assign rsp_mode_count = mode_count_ff;

   assign status.win_empty = (r0_ff > r1_ff) || (c0_ff > c1_ff);
   assign status.acc_last  = (y_ff == r1_ff) && (x_ff == c1_ff);
   assign status.pipe_busy = fr_vld_ff || hs_vld_ff;
   assign status.bin_last  = (bin_ff == BIN_W'(BINS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

[hw/rtl/gray_window_mode_filter.sv]
// ----------------------------------------------------------------------------
// gray_window_mode_filter
// window mode (oil painting) filter on an 8-bit grayscale frame
// ----------------------------------------------------------------------------
// req channel: a load transfer (action 0) writes req_pixel_in into the frame
//   store at (req_row, req_col) and gives no result; loads are taken one per
//   cycle while no compute runs. a compute transfer (action 1) returns one rsp
//   transfer with the most frequent intensity of the clipped square window
//   and its count. window pixels are read one per cycle, then the 256
//   histogram bins are scanned one per cycle; rsp_valid and req_ready rise
//   together when the result is loaded into the output register.
// one compute is in flight at a time; req_ready is low while it runs.
// csr port: csr_we writes image_width, image_height or window_radius,
//   clamped to their legal ranges; write only while the block is idle.
// reset: a pass clears all 256 histogram bins, req_ready stays low meanwhile;
//   frame store contents are undefined until loaded.
// rsp stall: the result waits in an output register; loads are still taken,
//   and a following compute holds its result until the register is free.
// ----------------------------------------------------------------------------
module gray_window_mode_filter #(
   parameter int MAX_WIDTH  = gwmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gwmf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = gwmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gwmf_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [gwmf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [gwmf_pkg::COORD_W-1:0]    req_row,
   input  logic [gwmf_pkg::COORD_W-1:0]    req_col,
   input  logic [gwmf_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gwmf_pkg::PIX_W-1:0]      rsp_mode_value,
   output logic [gwmf_pkg::CNT_W-1:0]      rsp_mode_count
);
   import gwmf_pkg::*;

   gwmf_cmd_type    cmd;
   gwmf_status_type status;

   gwmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   gwmf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

[tb/tb_gray_window_mode_filter.sv]
// ----------------------------------------------------------------------------
// tb_gray_window_mode_filter
// self-checking bench for the window mode filter: loads build the frame,
// computes are predicted from a private copy of the frame and configuration,
// and every result is compared in order under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_gray_window_mode_filter;
   import gwmf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int FRAME_W      = DEF_MAX_WIDTH;
   localparam int FRAME_H      = DEF_MAX_HEIGHT;
   localparam int IDLE_SETTLE  = 32;
   localparam int DRAIN_CYCLES = 800;
   localparam int HOLD_CYCLES  = 4000;
   localparam int LIMIT_CYCLES = 5_000_000;
   localparam logic [PIX_W-1:0] TILE [12] = '{8'h00, 8'hFF, 8'hFF, 8'h07,
                                              8'h00, 8'h55, 8'hAA, 8'h07,
                                              8'hFF, 8'h80, 8'h01, 8'h07};

   typedef struct {
      logic               action;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pix;
   } pixel_req_type;

   typedef struct {
      logic [PIX_W-1:0] value;
      logic [CNT_W-1:0] count;
   } mode_result_type;

   logic               clock;
   logic               reset        = 1'b1;
   logic               csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic               req_action   = ACT_LOAD;
   logic [COORD_W-1:0] req_row      = '0;
   logic [COORD_W-1:0] req_col      = '0;
   logic [PIX_W-1:0]   req_pixel_in = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic [PIX_W-1:0]   rsp_mode_value;
   logic [CNT_W-1:0]   rsp_mode_count;

   // configuration copy as the block holds it after clamping
   int img_cols = 64;
   int img_rows = 64;
   int win_rad  = 1;

   logic [PIX_W-1:0] frame_copy [FRAME_W*FRAME_H];
   bit               seen_px    [FRAME_W*FRAME_H];
   pixel_req_type    req_backlog [$];
   mode_result_type  mode_expected [$];
   int               shade [16];
   int               shade_n;

   int n_queued   = 0;
   int n_loads    = 0;
   int n_computes = 0;
   int n_checked  = 0;
   int n_settings = 0;
   int fail_count = 0;

   int   send_gap   = 0;
   int   send_quiet = 0;
   int   recv_gap   = 0;
   int   recv_quiet = 0;
   int   hold_left  = 0;
   bit   hold_done  = 1'b0;
   logic hold_req   = 1'b0;

   gray_window_mode_filter uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("timeout with %0d results still outstanding", mode_expected.size());
      $display("status: fail");
      $finish;
   end

   function automatic int clip_range(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int idle_len(inout int quiet_left);
      int pick;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) quiet_left = $urandom_range(20, 80);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 250);
   endfunction

   // window clipped at the image edges; empty when r0 > r1 or c0 > c1
   function automatic void window_span(input int row, input int col,
                                       output int r0, output int r1,
                                       output int c0, output int c1);
      r0 = (row - win_rad < 0) ? 0 : row - win_rad;
      r1 = (row + win_rad > img_rows - 1) ? img_rows - 1 : row + win_rad;
      c0 = (col - win_rad < 0) ? 0 : col - win_rad;
      c1 = (col + win_rad > img_cols - 1) ? img_cols - 1 : col + win_rad;
   endfunction

   function automatic mode_result_type predict_mode(input int row, input int col);
      int r0, r1, c0, c1;
      int tally [BINS];
      mode_result_type res;
      res.value = '0;
      res.count = '0;
      foreach (tally[i]) tally[i] = 0;
      window_span(row, col, r0, r1, c0, c1);
      for (int y = r0; y <= r1; y++)
         for (int x = c0; x <= c1; x++)
            tally[frame_copy[y * FRAME_W + x]]++;
      // strict compare keeps the lowest intensity on a tie
      for (int i = 0; i < BINS; i++)
         if (tally[i] > res.count) begin
            res.count = CNT_W'(tally[i]);
            res.value = PIX_W'(i);
         end
      return res;
   endfunction

   // driver
   always @(posedge clock) begin : drive
      pixel_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_action == ACT_LOAD) begin
               frame_copy[int'(req_row) * FRAME_W + int'(req_col)] = req_pixel_in;
               n_loads++;
            end else begin
               mode_expected.push_back(predict_mode(int'(req_row), int'(req_col)));
               n_computes++;
            end
            send_gap = idle_len(send_quiet);
         end
         if (req_valid && !req_ready) begin
            // hold the offered transfer
         end else if (send_gap > 0 || req_backlog.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            nxt = req_backlog.pop_front();
            req_valid    <= 1'b1;
            req_action   <= nxt.action;
            req_row      <= nxt.row;
            req_col      <= nxt.col;
            req_pixel_in <= nxt.pix;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            recv_gap = idle_len(recv_quiet);
         else if (rsp_ready && !rsp_valid && $urandom_range(0, 15) == 0)
            recv_gap = $urandom_range(1, 12);
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      mode_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mode_expected.size() == 0) begin
            $error("result transfer with nothing expected: mode_value %0d mode_count %0d",
                   rsp_mode_value, rsp_mode_count);
            fail_count++;
         end else begin
            want = mode_expected.pop_front();
            if (rsp_mode_value !== want.value) begin
               $error("mode_value expected %0d actual %0d", want.value, rsp_mode_value);
               fail_count++;
            end
            if (rsp_mode_count !== want.count) begin
               $error("mode_count expected %0d actual %0d", want.count, rsp_mode_count);
               fail_count++;
            end
            n_checked++;
         end
      end
   end

   function automatic int pick_shade();
      if (shade_n == 0) return $urandom_range(0, 255);
      return shade[$urandom_range(0, shade_n - 1)];
   endfunction

   task automatic set_shades(input int count);
      shade_n = count;
      foreach (shade[i]) shade[i] = $urandom_range(0, 255);
   endtask

   task automatic push_item(input logic act, input int row, input int col, input int pix);
      pixel_req_type it;
      it.action = act;
      it.row    = COORD_W'(row);
      it.col    = COORD_W'(col);
      it.pix    = PIX_W'(pix);
      req_backlog.push_back(it);
      n_queued++;
      if (act == ACT_LOAD) seen_px[row * FRAME_W + col] = 1'b1;
   endtask

   // loads any pixel of the window not yet written, then asks for the mode
   task automatic queue_compute(input int row, input int col);
      int r0, r1, c0, c1;
      window_span(row, col, r0, r1, c0, c1);
      for (int y = r0; y <= r1; y++)
         for (int x = c0; x <= c1; x++)
            if (!seen_px[y * FRAME_W + x]) push_item(ACT_LOAD, y, x, pick_shade());
      push_item(ACT_COMPUTE, row, col, $urandom_range(0, 255));
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'(data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_IMAGE_WIDTH:   img_cols = clip_range(int'(v), 1, FRAME_W);
         CSR_IMAGE_HEIGHT:  img_rows = clip_range(int'(v), 1, FRAME_H);
         CSR_WINDOW_RADIUS: win_rad  = clip_range(int'(v[RAD_W-1:0]), 1, DEF_MAX_RADIUS);
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int w_raw, input int h_raw, input int r_raw);
      csr_write(CSR_IMAGE_WIDTH, w_raw);
      csr_write(CSR_IMAGE_HEIGHT, h_raw);
      csr_write(CSR_WINDOW_RADIUS, r_raw);
      csr_write(CSR_SPARE, $urandom_range(0, 127));
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic wait_idle();
      while (n_loads + n_computes != n_queued || mode_expected.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input int w_raw, input int h_raw, input int r_raw,
                            input int count, input int palette, input bit stall_out);
      int start;
      apply_setting(w_raw, h_raw, r_raw);
      set_shades(palette);
      if (stall_out) begin
         @(posedge clock);
         hold_req <= 1'b1;
      end
      start = n_queued;
      while (n_queued - start < count) begin
         if ($urandom_range(0, 1) == 0)
            push_item(ACT_LOAD, $urandom_range(0, 63), $urandom_range(0, 63), pick_shade());
         else if ($urandom_range(0, 99) < 85)
            queue_compute($urandom_range(0, img_rows - 1), $urandom_range(0, img_cols - 1));
         else
            queue_compute($urandom_range(0, 63), $urandom_range(0, 63));
      end
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      // small 4 x 3 image: corners, edges, ties, unique window, empty windows
      apply_setting(4, 3, 1);
      set_shades(0);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 4; x++)
            push_item(ACT_LOAD, y, x, TILE[y * 4 + x]);
      push_item(ACT_LOAD, 63, 63, 8'h3C);
      push_item(ACT_LOAD, 0, 63, 8'hC3);
      queue_compute(0, 0);
      queue_compute(0, 1);
      queue_compute(1, 1);
      queue_compute(1, 3);
      queue_compute(2, 3);
      queue_compute(2, 1);
      queue_compute(3, 4);
      queue_compute(63, 63);
      queue_compute(0, 63);
      wait_idle();

      // full radius window of one intensity gives the largest count
      apply_setting(64, 64, 10);
      set_shades(1);
      queue_compute(42, 42);
      queue_compute(42, 43);
      wait_idle();

      run_phase(127, 0, 0, 25, 0, 1'b0);
      run_phase(16, 16, 8'h7F, 30, 3, 1'b0);
      run_phase(0, 100, 2, 25, 0, 1'b0);
      run_phase(64, 64, 1, 70, 8, 1'b1);
      run_phase(37, 23, 5, 30, 16, 1'b0);
      run_phase(64, 64, 3, 35, 0, 1'b0);
      run_phase(9, 50, 8'h1A, 20, 2, 1'b0);
      run_phase(12, 12, 13, 20, 4, 1'b0);

      while (n_loads + n_computes != n_queued || mode_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mode_expected.size() != 0) begin
         $error("%0d expected results never arrived", mode_expected.size());
         fail_count++;
      end
      $display("run covered %0d pixel loads and %0d window computes, %0d results checked",
               n_loads, n_computes, n_checked);
      $display("%0d register settings applied, clamped values and the spare index included",
               n_settings);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
